>>> rtl/core/tsrb_pkg.sv
// Shared types and constants for the TCP SYN+ACK reply builder.
package tsrb_pkg;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'h06;
  localparam logic [5:0]  FlagsMask     = 6'h3F;
  localparam logic [5:0]  FlagsSynAck   = 6'h12;
  // 0x4500 + total length 40 + (TTL 255, proto 6)
  localparam logic [16:0] IpHdrConst    = 17'h1442E;
  // pseudo proto 6 + length 20, 0x5010 data offset/flags, window 0xFFFF
  localparam logic [17:0] TcpHdrConst   = 18'h0001A + 18'h05010 + 18'h0FFFF;
  localparam logic [15:0] LocalPortRst  = 16'd0;
  localparam logic [15:0] ServerPortRst = 16'd80;
  localparam int unsigned CfgAddrW      = 3;

  typedef enum logic {
    REG_LOCAL_PORT  = 1'b0,
    REG_SERVER_PORT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [47:0] rx_dst_mac;
    logic [47:0] rx_src_mac;
    logic [15:0] rx_ethertype;
    logic [7:0]  rx_protocol;
    logic [31:0] rx_src_ip;
    logic [31:0] rx_dst_ip;
    logic [15:0] rx_dst_port;
    logic [31:0] rx_seq;
    logic [31:0] rx_ack;
    logic [7:0]  rx_flags;
  } rx_item_t;

  typedef struct packed {
    logic        send_reply;
    logic [47:0] tx_dst_mac;
    logic [47:0] tx_src_mac;
    logic [31:0] tx_src_ip;
    logic [31:0] tx_dst_ip;
    logic [15:0] ip_header_checksum;
    logic [31:0] tx_seq;
    logic [31:0] tx_ack;
    logic [15:0] tcp_checksum;
  } tx_item_t;

  // after filter / increment stage
  typedef struct packed {
    logic        match;
    logic [47:0] tx_dst_mac;
    logic [47:0] tx_src_mac;
    logic [31:0] tx_src_ip;
    logic [31:0] tx_dst_ip;
    logic [31:0] tx_seq;
    logic [31:0] tx_ack;
    logic [17:0] ip_words;
    logic [16:0] port_sum;
    logic [16:0] seq_words;
  } s1_t;

  // after summing stage
  typedef struct packed {
    logic        match;
    logic [47:0] tx_dst_mac;
    logic [47:0] tx_src_mac;
    logic [31:0] tx_src_ip;
    logic [31:0] tx_dst_ip;
    logic [31:0] tx_seq;
    logic [31:0] tx_ack;
    logic [18:0] ip_sum;
    logic [20:0] tcp_sum;
  } s2_t;

  // end-around carry fold and complement
  function automatic logic [15:0] csum_fold(input logic [20:0] sum);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {12'd0, sum[20:16]} + {1'b0, sum[15:0]};
    s2 = {16'd0, s1[16]} + {1'b0, s1[15:0]};
    return ~s2[15:0];
  endfunction

endpackage

>>> rtl/core/tsrb_filter.sv
// Stage 1: frame filter, ack increment and first partial checksum sums.
module tsrb_filter import tsrb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  rx_item_t    in_data,
  input  logic [15:0] local_port,
  input  logic [15:0] server_port,
  output logic        out_valid,
  input  logic        out_stall,
  output s1_t         out_data
);

  logic adv;
  s1_t  nxt;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    nxt.match = (in_data.rx_ethertype == EtherTypeIpv4) &&
                (in_data.rx_protocol == ProtoTcp) &&
                (in_data.rx_dst_port == local_port) &&
                ((in_data.rx_flags[5:0] & FlagsMask) == FlagsSynAck);
    nxt.tx_dst_mac = in_data.rx_src_mac;
    nxt.tx_src_mac = in_data.rx_dst_mac;
    nxt.tx_src_ip  = in_data.rx_dst_ip;
    nxt.tx_dst_ip  = in_data.rx_src_ip;
    nxt.tx_seq     = in_data.rx_ack;
    nxt.tx_ack     = in_data.rx_seq + 32'd1;
    nxt.ip_words   = {2'd0, in_data.rx_src_ip[31:16]} + {2'd0, in_data.rx_src_ip[15:0]} +
                     {2'd0, in_data.rx_dst_ip[31:16]} + {2'd0, in_data.rx_dst_ip[15:0]};
    nxt.port_sum   = {1'b0, local_port} + {1'b0, server_port};
    nxt.seq_words  = {1'b0, in_data.rx_ack[31:16]} + {1'b0, in_data.rx_ack[15:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

>>> rtl/core/tsrb_sum.sv
// Stage 2: full ones' complement sums for the IP and TCP checksums.
module tsrb_sum import tsrb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  s1_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output s2_t  out_data
);

  logic adv;
  s2_t  nxt;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    nxt.match      = in_data.match;
    nxt.tx_dst_mac = in_data.tx_dst_mac;
    nxt.tx_src_mac = in_data.tx_src_mac;
    nxt.tx_src_ip  = in_data.tx_src_ip;
    nxt.tx_dst_ip  = in_data.tx_dst_ip;
    nxt.tx_seq     = in_data.tx_seq;
    nxt.tx_ack     = in_data.tx_ack;
    nxt.ip_sum     = {1'b0, in_data.ip_words} + {2'd0, IpHdrConst};
    nxt.tcp_sum    = {3'd0, in_data.ip_words} + {4'd0, in_data.port_sum} +
                     {4'd0, in_data.seq_words} + {5'd0, in_data.tx_ack[31:16]} +
                     {5'd0, in_data.tx_ack[15:0]} + {3'd0, TcpHdrConst};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

>>> rtl/core/tsrb_fold.sv
// Stage 3: checksum fold, reply gating and output register.
module tsrb_fold import tsrb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  s2_t      in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tx_item_t out_data
);

  logic     adv;
  tx_item_t nxt;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    nxt = '0;
    if (in_data.match) begin
      nxt.send_reply         = 1'b1;
      nxt.tx_dst_mac         = in_data.tx_dst_mac;
      nxt.tx_src_mac         = in_data.tx_src_mac;
      nxt.tx_src_ip          = in_data.tx_src_ip;
      nxt.tx_dst_ip          = in_data.tx_dst_ip;
      nxt.ip_header_checksum = csum_fold({2'd0, in_data.ip_sum});
      nxt.tx_seq             = in_data.tx_seq;
      nxt.tx_ack             = in_data.tx_ack;
      nxt.tcp_checksum       = csum_fold(in_data.tcp_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

>>> rtl/core/tcp_synack_reply_builder.sv
// Top level of the TCP SYN+ACK reply builder: register port and three-stage pipeline.
// Stages in order: filter, sum, fold; each registers its result, and the fold
// stage's register is the output register that drives out_valid and out_data.
// Throughput: one item per cycle; each stage holds one item and advances when
// the stage after it is empty or moving, so a stall backs up without loss.
// Every item gives one result; non-matching frames give an all-zero result.
// Reset (rst, synchronous): all stage valid bits clear, local_port = 0,
// server_port = 80.
module tcp_synack_reply_builder import tsrb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // receive side
  input  logic                in_valid,
  output logic                in_stall,
  input  rx_item_t            in_data,
  // reply side
  output logic                out_valid,
  input  logic                out_stall,
  output tx_item_t            out_data,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [15:0] local_port;
  logic [15:0] server_port;
  reg_idx_t    reg_sel;
  logic        wr_en;

  logic s1_valid;
  logic s1_stall;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_stall;
  s2_t  s2_data;

  // Registers sit at byte offsets 0 and 4; bit 2 picks the register.
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_port  <= LocalPortRst;
      server_port <= ServerPortRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_LOCAL_PORT:  local_port  <= pwdata[15:0];
        REG_SERVER_PORT: server_port <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LOCAL_PORT:  prdata = {16'd0, local_port};
      REG_SERVER_PORT: prdata = {16'd0, server_port};
      default:         prdata = '0;
    endcase
  end

  // Stage 1: filter match, ack + 1, address/port/seq partial sums.
  tsrb_filter u_filter (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .local_port  (local_port),
    .server_port (server_port),
    .out_valid   (s1_valid),
    .out_stall   (s1_stall),
    .out_data    (s1_data)
  );

  // Stage 2: full unfolded checksum sums.
  tsrb_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_stall  (s1_stall),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_stall (s2_stall),
    .out_data  (s2_data)
  );

  // Stage 3: fold, complement, zero non-replies; doubles as the output register.
  tsrb_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_stall  (s2_stall),
    .in_data   (s2_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> sim/tcp_synack_reply_builder_tb.sv
// Self-checking testbench for the TCP SYN+ACK reply builder.
`timescale 1ns / 100ps

module tcp_synack_reply_builder_tb;
  import tsrb_pkg::*;

  // Holds the replies the block owes us, in order, and works them out from
  // the received header fields and its own copy of the two port registers.
  class reply_scoreboard;
    tx_item_t    pending[$];
    logic [15:0] local_port;
    logic [15:0] server_port;
    int unsigned errors;

    function new();
      local_port  = LocalPortRst;
      server_port = ServerPortRst;
      errors      = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_LOCAL_PORT: begin
          local_port = val[15:0];
        end
        REG_SERVER_PORT: begin
          server_port = val[15:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Both 16-bit halves of a 32-bit word, as added into an Internet checksum.
    function logic [31:0] halves(logic [31:0] v);
      return {16'd0, v[31:16]} + {16'd0, v[15:0]};
    endfunction

    // Two end-around carry folds, then the ones' complement.
    function logic [15:0] fold(logic [31:0] s);
      logic [31:0] t;
      t = {16'd0, s[31:16]} + {16'd0, s[15:0]};
      t = {16'd0, t[31:16]} + {16'd0, t[15:0]};
      return ~t[15:0];
    endfunction

    function tx_item_t build_reply(rx_item_t rx);
      tx_item_t    r;
      logic [31:0] s;
      r = '0;
      // anything but a SYN+ACK to our port gives an all-zero result
      if (rx.rx_ethertype != EtherTypeIpv4 || rx.rx_protocol != ProtoTcp ||
          rx.rx_dst_port != local_port || rx.rx_flags[5:0] != FlagsSynAck) begin
        return r;
      end
      r.send_reply = 1'b1;
      r.tx_dst_mac = rx.rx_src_mac;
      r.tx_src_mac = rx.rx_dst_mac;
      r.tx_src_ip  = rx.rx_dst_ip;
      r.tx_dst_ip  = rx.rx_src_ip;
      r.tx_seq     = rx.rx_ack;
      r.tx_ack     = rx.rx_seq + 32'd1;
      // IP header: ver/ihl/tos, length 40, id 0, frag 0, ttl 255 + proto 6
      s = 32'h4500 + 32'd40 + 32'hFF06 + halves(r.tx_src_ip) + halves(r.tx_dst_ip);
      r.ip_header_checksum = fold(s);
      // pseudo-header (proto 6, length 20) plus the 20-byte ACK header
      s = 32'd6 + 32'd20 + halves(r.tx_src_ip) + halves(r.tx_dst_ip);
      s = s + {16'd0, local_port} + {16'd0, server_port};
      s = s + halves(r.tx_seq) + halves(r.tx_ack) + 32'h5010 + 32'hFFFF;
      r.tcp_checksum = fold(s);
      return r;
    endfunction

    function void note_frame(rx_item_t rx);
      pending.push_back(build_reply(rx));
    endfunction

    function void match_field(string name, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(tx_item_t got);
      tx_item_t want;
      if (pending.size() == 0) begin
        $error("reply item with nothing outstanding: %0h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      match_field("send_reply", 48'(want.send_reply), 48'(got.send_reply));
      match_field("tx_dst_mac", want.tx_dst_mac, got.tx_dst_mac);
      match_field("tx_src_mac", want.tx_src_mac, got.tx_src_mac);
      match_field("tx_src_ip", 48'(want.tx_src_ip), 48'(got.tx_src_ip));
      match_field("tx_dst_ip", 48'(want.tx_dst_ip), 48'(got.tx_dst_ip));
      match_field("ip_header_checksum", 48'(want.ip_header_checksum),
                  48'(got.ip_header_checksum));
      match_field("tx_seq", 48'(want.tx_seq), 48'(got.tx_seq));
      match_field("tx_ack", 48'(want.tx_ack), 48'(got.tx_ack));
      match_field("tcp_checksum", 48'(want.tcp_checksum), 48'(got.tcp_checksum));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's pins. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  rx_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tx_item_t            out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [CfgAddrW-1:0] paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;

  reply_scoreboard sb = new();

  // 0: no idling on either side, 1: random gaps and stalls
  int unsigned idle_mode = 1;

  always #5 clk = ~clk;

  tcp_synack_reply_builder u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (idle_mode == 0) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  // ---------------------------------------------------------------------------
  // Reply side: stall runs of random length, changed on the falling edge only.
  // One assignment per edge, so the level is never glitched within a step.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    int unsigned len;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        len = pick_gap();
        if (len > 0) begin
          out_stall <= 1'b1;
          hold = len - 1;
        end else begin
          out_stall <= 1'b0;
          hold = $urandom_range(0, 5);
        end
      end
    end
  end

  // Results are taken at the rising edge where valid is high and stall low.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_reply(out_data);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Presents one frame, waits out any stall, then records it as accepted.
  // Valid stays high into the next call when no gap is inserted.
  task automatic drive_frame(rx_item_t rx);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= rx_item_t'({$urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom(), $urandom(), $urandom()});
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= rx;
    do @(posedge clk); while (in_stall);
    sb.note_frame(rx);
  endtask

  // Register access: setup cycle, then access cycle until pready.
  task automatic reg_access(bit wr, reg_idx_t idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) begin
      sb.set_reg(idx, wdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes both ports (junk in the upper bits) and reads them back.
  task automatic set_ports(logic [15:0] lport, logic [15:0] sport);
    logic [31:0] rd;
    reg_access(1'b1, REG_LOCAL_PORT, {16'($urandom()), lport}, rd);
    reg_access(1'b1, REG_SERVER_PORT, {16'($urandom()), sport}, rd);
    reg_access(1'b0, REG_LOCAL_PORT, '0, rd);
    if (rd[15:0] !== lport) begin
      $error("local_port readback: expected %0h, got %0h", lport, rd[15:0]);
      sb.errors++;
    end
    reg_access(1'b0, REG_SERVER_PORT, '0, rd);
    if (rd[15:0] !== sport) begin
      $error("server_port readback: expected %0h, got %0h", sport, rd[15:0]);
      sb.errors++;
    end
  endtask

  // Holds off the sender until every owed reply is out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A well-formed SYN+ACK to our current port, random everywhere else,
  // including the two ignored high flag bits.
  function automatic rx_item_t make_synack();
    rx_item_t rx;
    rx = rx_item_t'({$urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom()});
    rx.rx_ethertype  = EtherTypeIpv4;
    rx.rx_protocol   = ProtoTcp;
    rx.rx_dst_port   = sb.local_port;
    rx.rx_flags[5:0] = FlagsSynAck;
    return rx;
  endfunction

  // Random frame: mostly SYN+ACKs for us, some with exactly one filter
  // broken, the rest pure noise.
  function automatic rx_item_t make_frame();
    rx_item_t    rx;
    int unsigned r;
    rx = make_synack();
    r  = $urandom_range(0, 99);
    if (r >= 90) begin
      rx = rx_item_t'({$urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom(), $urandom()});
    end else if (r >= 65) begin
      case ($urandom_range(0, 3))
        0: rx.rx_ethertype = EtherTypeIpv4 ^ 16'($urandom_range(1, 65535));
        1: rx.rx_protocol  = ProtoTcp ^ 8'($urandom_range(1, 255));
        2: rx.rx_dst_port  = sb.local_port ^ 16'($urandom_range(1, 65535));
        default: rx.rx_flags[5:0] = FlagsSynAck ^ 6'($urandom_range(1, 63));
      endcase
    end
    return rx;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rx_item_t    rx;
    logic [15:0] lports[5];
    logic [15:0] sports[5];

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames under the reset ports (local 0, server 80).
    rx = make_synack();
    rx.rx_dst_mac = '0; rx.rx_src_mac = '0; rx.rx_src_ip = '0; rx.rx_dst_ip = '0;
    rx.rx_seq = '0; rx.rx_ack = '0; rx.rx_flags = 8'h12;
    drive_frame(rx);
    // all-ones content, high flag bits set, sequence wraps to zero
    rx = make_synack();
    rx.rx_dst_mac = '1; rx.rx_src_mac = '1; rx.rx_src_ip = '1; rx.rx_dst_ip = '1;
    rx.rx_seq = '1; rx.rx_ack = '1; rx.rx_flags = 8'hD2;
    drive_frame(rx);
    rx = make_synack(); rx.rx_seq = 32'hFFFF_FFFF; rx.rx_flags = 8'h52; drive_frame(rx);
    rx = make_synack(); rx.rx_flags = 8'h92; drive_frame(rx);
    // each filter failing on its own
    rx = make_synack(); rx.rx_ethertype = 16'h86DD; drive_frame(rx);
    rx = make_synack(); rx.rx_ethertype = 16'hFFFF; drive_frame(rx);
    rx = make_synack(); rx.rx_ethertype = 16'h0000; drive_frame(rx);
    rx = make_synack(); rx.rx_protocol = 8'd17; drive_frame(rx);
    rx = make_synack(); rx.rx_protocol = 8'hFF; drive_frame(rx);
    rx = make_synack(); rx.rx_dst_port = 16'd1; drive_frame(rx);
    rx = make_synack(); rx.rx_dst_port = 16'hFFFF; drive_frame(rx);
    rx = make_synack(); rx.rx_flags = 8'h02; drive_frame(rx);
    rx = make_synack(); rx.rx_flags = 8'h10; drive_frame(rx);
    rx = make_synack(); rx.rx_flags = 8'h3F; drive_frame(rx);
    rx = make_synack(); rx.rx_flags = 8'h13; drive_frame(rx);
    rx = make_synack(); rx.rx_flags = 8'hED; drive_frame(rx);
    drive_frame(rx_item_t'('0));
    drive_frame(rx_item_t'('1));
    drive_frame(make_synack());
    drain();

    // Port settings: both extremes each way, both at all-ones, and random ones.
    lports = '{16'hFFFF, 16'h0000, 16'($urandom()), 16'hFFFF, 16'($urandom())};
    sports = '{16'h0000, 16'hFFFF, 16'($urandom()), 16'hFFFF, 16'($urandom())};
    foreach (lports[p]) begin
      set_ports(lports[p], sports[p]);
      // directed edge checks under each new setting
      rx = make_synack(); rx.rx_seq = 32'hFFFF_FFFF; drive_frame(rx);
      for (int n = 0; n < 150; n++) begin
        // bursts pick at random between back-to-back traffic and random idling
        if (n % 50 == 0) begin
          idle_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
        end
        // one mid-phase hold-off until every owed reply has come out
        if (p == 2 && n == 75) begin
          drain();
        end
        drive_frame(make_frame());
      end
      drain();
    end

    // Drained above; let the clock run on to catch anything stray.
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tcp_synack_reply_builder_tb passed");
    end else begin
      $display("tcp_synack_reply_builder_tb failed");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("tcp_synack_reply_builder_tb failed");
    $finish;
  end

endmodule
